FILE: sv/esc_pkg.sv
// Shared types and constants for the environmental sensor compensation pipeline.
// Used by environmental_sensor_compensation and its checker; no dependencies.
`default_nettype none
package esc_pkg;

  // register index of the configuration port
  typedef enum logic [2:0] {
    CFG_TEMP    = 3'd0,
    CFG_PRESS_A = 3'd1,
    CFG_PRESS_B = 3'd2,
    CFG_PRESS_C = 3'd3,
    CFG_HUM     = 3'd4
  } esc_cfg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int COEF_W     = 40;

  // pressure divider: radix-2 restoring, DIV_BITS quotient bits per stage
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = 12;
  localparam int DIV_W      = DIV_STAGES * DIV_BITS;
  localparam int DEN_W      = 26;
  localparam int REM_W      = DEN_W + 1;

  // stages before the divider, divider, and after it
  localparam int PRE_STAGES  = 11;
  localparam int POST_STAGES = 7;
  localparam int LATENCY     = PRE_STAGES + DIV_STAGES + POST_STAGES;

  // ceil(2^32 / 100), exact quotient for magnitudes below 2^30
  localparam logic [25:0] RECIP100 = 26'd42949673;

  localparam logic [17:0] PRESS_MAX = 18'd262143;
  localparam logic [16:0] HUM_MAX   = 17'd102400;

  typedef struct packed {
    logic               zero;
    logic               neg;
    logic               br;
    logic signed [15:0] tsc;
    logic signed [23:0] v1h;
    logic signed [26:0] v2h;
  } esc_side_t;

endpackage
`default_nettype wire

FILE: sv/environmental_sensor_compensation.sv
// Depth: 30 register stages, the last of them the output register.
// Throughput: one item per cycle while the output is not stalled; the pressure divider is
// pipelined, 4 quotient bits per stage over 12 stages, and sets the depth.
// A stall on the output freezes every stage; nothing is lost or repeated.
// Synchronous active-low reset clears valid bits and coefficient registers.
// Depends on esc_pkg.
`default_nettype none
module environmental_sensor_compensation (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [19:0]                    in_raw_temperature,
  input  wire logic [19:0]                    in_raw_pressure,
  input  wire logic [15:0]                    in_raw_humidity,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [15:0]                  out_temperature_centi,
  output logic [17:0]                         out_pressure_pascal,
  output logic [16:0]                         out_humidity_scaled,
  output logic                                out_divide_guard,
  input  wire logic                           cfg_we,
  input  wire logic [esc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [esc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int N      = esc_pkg::LATENCY;
  localparam int DVS    = esc_pkg::DIV_STAGES;
  localparam int DIV_W  = esc_pkg::DIV_W;
  localparam int DEN_W  = esc_pkg::DEN_W;
  localparam int REM_W  = esc_pkg::REM_W;
  localparam int DBITS  = esc_pkg::DIV_BITS;

  logic         adv;
  logic [N-1:0] vld_r;

  // configuration
  logic [esc_pkg::COEF_W-1:0]     temp_r, press_a_r, press_b_r, press_c_r;
  logic [esc_pkg::CFG_DATA_W-1:0] hum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r    <= '0;
      press_a_r <= '0;
      press_b_r <= '0;
      press_c_r <= '0;
      hum_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        esc_pkg::CFG_TEMP:    temp_r    <= cfg_wdata[esc_pkg::COEF_W-1:0];
        esc_pkg::CFG_PRESS_A: press_a_r <= cfg_wdata[esc_pkg::COEF_W-1:0];
        esc_pkg::CFG_PRESS_B: press_b_r <= cfg_wdata[esc_pkg::COEF_W-1:0];
        esc_pkg::CFG_PRESS_C: press_c_r <= cfg_wdata[esc_pkg::COEF_W-1:0];
        esc_pkg::CFG_HUM:     hum_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [15:0]        ct1u;
  logic signed [15:0] ct2, cp2, cp4, cp5, cp8, cp9;
  logic signed [7:0]  ct3, cp3, cp6, cp7, ch3, ch4, ch5;
  logic signed [16:0] cp1;
  logic [11:0]        ch1, ch2;

  assign ct1u = temp_r[15:0];
  assign ct2  = $signed(temp_r[31:16]);
  assign ct3  = $signed(temp_r[39:32]);
  assign cp1  = $signed({1'b0, press_a_r[15:0]});
  assign cp2  = $signed(press_a_r[31:16]);
  assign cp3  = $signed(press_a_r[39:32]);
  assign cp4  = $signed(press_b_r[15:0]);
  assign cp5  = $signed(press_b_r[31:16]);
  assign cp6  = $signed(press_b_r[39:32]);
  assign cp7  = $signed(press_c_r[7:0]);
  assign cp8  = $signed(press_c_r[23:8]);
  assign cp9  = $signed(press_c_r[39:24]);
  assign ch1  = hum_r[11:0];
  assign ch2  = hum_r[23:12];
  assign ch3  = $signed(hum_r[31:24]);
  assign ch4  = $signed(hum_r[39:32]);
  assign ch5  = $signed(hum_r[47:40]);

  // handshake: whole pipe advances together
  assign adv       = !vld_r[N-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[N-2:0], in_valid};
    end
  end

  // stage registers
  logic signed [18:0] s1_a_r;
  logic signed [17:0] s1_d_r;
  logic [19:0]        s1_ap_r, s2_ap_r, s3_ap_r, s4_ap_r, s5_ap_r, s6_ap_r, s7_ap_r, s8_ap_r;
  logic [15:0]        s1_ah_r, s2_ah_r, s3_ah_r, s4_ah_r, s5_ah_r, s6_ah_r, s7_ah_r, s8_ah_r;
  logic signed [34:0] s2_m1_r;
  logic signed [35:0] s2_dd_r;
  logic signed [23:0] s3_v1t_r;
  logic signed [31:0] s3_m2_r;
  logic signed [24:0] s4_tf_r;
  logic signed [19:0] s5_ts_r, s6_ts_r, s7_ts_r, s8_ts_r, s9_ts_r, s10_ts_r;
  logic signed [24:0] s5_v1p_r;
  logic signed [45:0] s6_sq_r;
  logic signed [40:0] s6_mv15_r, s6_mp2_r, s7_mv15_r, s7_mp2_r;
  logic signed [27:0] s6_x3_r, s6_x4_r, s6_x5_r;
  logic signed [42:0] s7_a6_r;
  logic signed [40:0] s7_a3_r;
  logic [20:0]        s7_q3m_r, s7_q4m_r, s7_q5m_r;
  logic [2:0]         s7_qneg_r;
  logic signed [42:0] s8_v2_r;
  logic signed [22:0] s8_v3a_r;
  logic signed [21:0] s8_q3_r, s8_q4_r, s8_q5_r;
  logic signed [32:0] s9_prp_r;
  logic signed [40:0] s9_v3m_r;
  logic signed [23:0] s9_v1h_r, s9_hs_r, s10_v1h_r;
  logic signed [45:0] s10_pr0_r;
  logic signed [25:0] s10_v3_r;
  logic signed [36:0] s10_v2hp_r;

  logic [REM_W-1:0]   dv_rem_r  [DVS+1];
  logic [DIV_W-1:0]   dv_num_r  [DVS+1];
  logic [DEN_W-1:0]   dv_den_r  [DVS+1];
  esc_pkg::esc_side_t dv_side_r [DVS+1];

  logic signed [49:0] o1_prd_r, o2_prd_r, o3_prd_r, o4_prd_r, o5_prd_r, o6_prd_r;
  logic signed [50:0] o1_hmp_r;
  logic               o1_zero_r, o2_zero_r, o3_zero_r, o4_zero_r, o5_zero_r, o6_zero_r;
  logic signed [15:0] o1_tsc_r, o2_tsc_r, o3_tsc_r, o4_tsc_r, o5_tsc_r, o6_tsc_r;
  logic [47:0]        o2_rl2_r;
  logic signed [47:0] o2_rhl_r;
  logic signed [45:0] o2_rh2_r;
  logic signed [63:0] o2_v2p_r;
  logic [16:0]        o2_hm_r, o3_hm_r, o4_hm_r, o5_hm_r, o6_hm_r;
  logic [63:0]        o3_rr_r;
  logic signed [50:0] o3_v2s_r, o4_v2s_r, o5_v2s_r;
  logic signed [48:0] o4_pl_r;
  logic [31:0]        o4_ph_r;
  logic signed [38:0] o5_v1_r;
  logic signed [47:0] o6_sm_r;
  logic signed [15:0] o7_tsc_r;
  logic [17:0]        o7_pr_r;
  logic [16:0]        o7_hm_r;
  logic               o7_guard_r;

  // combinational next values
  logic signed [18:0] s1_a_nxt;
  logic signed [17:0] s1_d_nxt;
  logic signed [34:0] s2_m1_nxt;
  logic signed [35:0] s2_dd_nxt;
  logic signed [23:0] s3_v1t_nxt, dd12;
  logic signed [31:0] s3_m2_nxt;
  logic signed [24:0] s4_tf_nxt;
  logic signed [27:0] tf5;
  logic signed [19:0] s5_ts_nxt;
  logic signed [24:0] s5_v1p_nxt;
  logic signed [22:0] qv;
  logic signed [45:0] s6_sq_nxt;
  logic signed [40:0] s6_mv15_nxt, s6_mp2_nxt;
  logic signed [27:0] s6_x3_nxt, s6_x4_nxt, s6_x5_nxt;
  logic signed [34:0] sq11;
  logic signed [32:0] sq13;
  logic signed [42:0] s7_a6_nxt;
  logic signed [40:0] s7_a3_nxt;
  logic [26:0]        xm3, xm4, xm5;
  logic [52:0]        hp3, hp4, hp5;
  logic signed [43:0] v2sum;
  logic signed [42:0] s8_v2_nxt;
  logic signed [40:0] v3sum;
  logic signed [22:0] s8_v3a_nxt;
  logic signed [21:0] s8_q3_nxt, s8_q4_nxt, s8_q5_nxt;
  logic signed [32:0] s9_prp_nxt;
  logic signed [23:0] v3b;
  logic signed [40:0] s9_v3m_nxt;
  logic signed [23:0] s9_v1h_nxt, s9_hs_nxt;
  logic signed [45:0] s10_pr0_nxt;
  logic signed [25:0] s10_v3_nxt;
  logic signed [36:0] s10_v2hp_nxt;
  logic signed [12:0] ch2s;
  logic               dv_br;
  logic signed [46:0] dv_d;
  logic [DIV_W-1:0]   dv_num_nxt;
  logic [DEN_W-1:0]   dv_den_nxt;
  esc_pkg::esc_side_t dv_side_nxt;
  logic signed [48:0] qs;
  logic signed [49:0] o1_prd_nxt;
  logic signed [50:0] o1_hmp_nxt;
  logic signed [46:0] rv;
  logic signed [22:0] rh;
  logic [23:0]        rl;
  logic [47:0]        o2_rl2_nxt;
  logic signed [47:0] o2_rhl_nxt, pq;
  logic signed [45:0] o2_rh2_nxt;
  logic signed [63:0] o2_v2p_nxt;
  logic [16:0]        o2_hm_nxt;
  logic [63:0]        o3_rr_nxt;
  logic signed [48:0] o4_pl_nxt;
  logic signed [47:0] phf;
  logic signed [63:0] prod9;
  logic signed [47:0] o6_sm_nxt;
  logic signed [50:0] pf;
  logic [17:0]        o7_pr_nxt;

  always_comb begin
    // temperature
    s1_a_nxt   = $signed({2'b00, in_raw_temperature[19:3]}) - $signed({2'b00, ct1u, 1'b0});
    s1_d_nxt   = $signed({2'b00, in_raw_temperature[19:4]}) - $signed({2'b00, ct1u});
    s2_m1_nxt  = s1_a_r * ct2;
    s2_dd_nxt  = s1_d_r * s1_d_r;
    s3_v1t_nxt = 24'(s2_m1_r >>> 11);
    dd12       = 24'(s2_dd_r >>> 12);
    s3_m2_nxt  = dd12 * ct3;
    s4_tf_nxt  = 25'(s3_v1t_r) + 25'(s3_m2_r >>> 14);
    tf5        = 28'(s4_tf_r) * 28'sd5;
    s5_ts_nxt  = 20'((tf5 + 28'sd128) >>> 8);
    s5_v1p_nxt = 25'(s4_tf_r >>> 1) - 25'sd64000;

    // pressure terms and humidity products
    qv          = 23'(s5_v1p_r >>> 2);
    s6_sq_nxt   = qv * qv;
    s6_mv15_nxt = s5_v1p_r * cp5;
    s6_mp2_nxt  = cp2 * s5_v1p_r;
    s6_x3_nxt   = s5_ts_r * ch3;
    s6_x4_nxt   = s5_ts_r * ch4;
    s6_x5_nxt   = s5_ts_r * ch5;

    sq11      = 35'(s6_sq_r >>> 11);
    sq13      = 33'(s6_sq_r >>> 13);
    s7_a6_nxt = sq11 * cp6;
    s7_a3_nxt = cp3 * sq13;
    // divide by 100 through reciprocal on magnitudes
    xm3 = s6_x3_r[27] ? 27'(-s6_x3_r) : 27'(s6_x3_r);
    xm4 = s6_x4_r[27] ? 27'(-s6_x4_r) : 27'(s6_x4_r);
    xm5 = s6_x5_r[27] ? 27'(-s6_x5_r) : 27'(s6_x5_r);
    hp3 = xm3 * esc_pkg::RECIP100;
    hp4 = xm4 * esc_pkg::RECIP100;
    hp5 = xm5 * esc_pkg::RECIP100;

    v2sum      = 44'(s7_a6_r) + (44'(s7_mv15_r) <<< 1);
    s8_v2_nxt  = 43'(v2sum >>> 2) + (43'(cp4) <<< 16);
    v3sum      = 41'(s7_a3_r >>> 3) + 41'(s7_mp2_r >>> 1);
    s8_v3a_nxt = 23'(v3sum >>> 18);
    s8_q3_nxt  = s7_qneg_r[0] ? -$signed({1'b0, s7_q3m_r}) : $signed({1'b0, s7_q3m_r});
    s8_q4_nxt  = s7_qneg_r[1] ? -$signed({1'b0, s7_q4m_r}) : $signed({1'b0, s7_q4m_r});
    s8_q5_nxt  = s7_qneg_r[2] ? -$signed({1'b0, s7_q5m_r}) : $signed({1'b0, s7_q5m_r});

    s9_prp_nxt = 33'sd1048576 - 33'($signed({1'b0, s8_ap_r})) - 33'(s8_v2_r >>> 12);
    v3b        = 24'sd32768 + 24'(s8_v3a_r);
    s9_v3m_nxt = v3b * cp1;
    s9_v1h_nxt = 24'($signed({1'b0, s8_ah_r})) - 24'($signed({1'b0, ch1, 4'b0000}))
                 - 24'(s8_q3_r >>> 1);
    s9_hs_nxt  = 24'(s8_q4_r) + 24'(s8_q5_r >>> 6) + 24'sd16384;

    ch2s         = $signed({1'b0, ch2});
    s10_pr0_nxt  = s9_prp_r * 13'sd3125;
    s10_v3_nxt   = 26'(s9_v3m_r >>> 15);
    s10_v2hp_nxt = ch2s * s9_hs_r;

    // divider entry
    dv_br      = s10_pr0_r >= 46'sd2147483648;
    dv_d       = dv_br ? 47'(s10_pr0_r) : (47'(s10_pr0_r) <<< 1);
    dv_num_nxt = dv_d[46] ? DIV_W'(-(DIV_W'(dv_d))) : DIV_W'(dv_d);
    dv_den_nxt = s10_v3_r[25] ? DEN_W'(-s10_v3_r) : DEN_W'(s10_v3_r);
    dv_side_nxt.zero = (s10_v3_r == '0);
    dv_side_nxt.neg  = dv_d[46] ^ s10_v3_r[25];
    dv_side_nxt.br   = dv_br;
    if (s10_ts_r > 20'sd32767) begin
      dv_side_nxt.tsc = 16'sh7fff;
    end else if (s10_ts_r < -20'sd32768) begin
      dv_side_nxt.tsc = 16'sh8000;
    end else begin
      dv_side_nxt.tsc = s10_ts_r[15:0];
    end
    dv_side_nxt.v1h = s10_v1h_r;
    dv_side_nxt.v2h = 27'(s10_v2hp_r >>> 10);

    // after divider
    qs = dv_side_r[DVS].neg ? -$signed({1'b0, dv_num_r[DVS]}) : $signed({1'b0, dv_num_r[DVS]});
    o1_prd_nxt = dv_side_r[DVS].br ? (50'(qs) <<< 1) : 50'(qs);
    o1_hmp_nxt = dv_side_r[DVS].v1h * dv_side_r[DVS].v2h;

    // r*r modulo 2^64 from a 24-bit low slice and a 23-bit high slice
    rv         = 47'(o1_prd_r >>> 3);
    rl         = rv[23:0];
    rh         = rv[46:24];
    o2_rl2_nxt = rl * rl;
    o2_rhl_nxt = rh * $signed({1'b0, rl});
    o2_rh2_nxt = rh * rh;
    pq         = 48'(o1_prd_r >>> 2);
    o2_v2p_nxt = pq * cp8;
    if (o1_hmp_r < 51'sd0) begin
      o2_hm_nxt = '0;
    end else if (o1_hmp_r > 51'(esc_pkg::HUM_MAX)) begin
      o2_hm_nxt = esc_pkg::HUM_MAX;
    end else begin
      o2_hm_nxt = o1_hmp_r[16:0];
    end

    o3_rr_nxt = 64'(o2_rl2_r) + 64'(64'(o2_rhl_r) <<< 25) + 64'(64'(o2_rh2_r) <<< 48);

    // p9 * rr modulo 2^64 from 32-bit halves
    o4_pl_nxt = cp9 * $signed({1'b0, o3_rr_r[31:0]});
    phf       = cp9 * $signed(o3_rr_r[63:32]);

    prod9 = 64'(o4_pl_r) + $signed({o4_ph_r, 32'h0000_0000});

    o6_sm_nxt = 48'((52'(o5_v1_r) + 52'(o5_v2s_r) + 52'(cp7)) >>> 4);

    pf = 51'(o6_prd_r) + 51'(o6_sm_r);
    if (o6_zero_r || pf < 51'sd0) begin
      o7_pr_nxt = '0;
    end else if (pf > 51'(esc_pkg::PRESS_MAX)) begin
      o7_pr_nxt = esc_pkg::PRESS_MAX;
    end else begin
      o7_pr_nxt = pf[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a_r  <= s1_a_nxt;
      s1_d_r  <= s1_d_nxt;
      s1_ap_r <= in_raw_pressure;
      s1_ah_r <= in_raw_humidity;

      s2_m1_r <= s2_m1_nxt;
      s2_dd_r <= s2_dd_nxt;
      s2_ap_r <= s1_ap_r;
      s2_ah_r <= s1_ah_r;

      s3_v1t_r <= s3_v1t_nxt;
      s3_m2_r  <= s3_m2_nxt;
      s3_ap_r  <= s2_ap_r;
      s3_ah_r  <= s2_ah_r;

      s4_tf_r <= s4_tf_nxt;
      s4_ap_r <= s3_ap_r;
      s4_ah_r <= s3_ah_r;

      s5_ts_r  <= s5_ts_nxt;
      s5_v1p_r <= s5_v1p_nxt;
      s5_ap_r  <= s4_ap_r;
      s5_ah_r  <= s4_ah_r;

      s6_sq_r   <= s6_sq_nxt;
      s6_mv15_r <= s6_mv15_nxt;
      s6_mp2_r  <= s6_mp2_nxt;
      s6_x3_r   <= s6_x3_nxt;
      s6_x4_r   <= s6_x4_nxt;
      s6_x5_r   <= s6_x5_nxt;
      s6_ts_r   <= s5_ts_r;
      s6_ap_r   <= s5_ap_r;
      s6_ah_r   <= s5_ah_r;

      s7_a6_r   <= s7_a6_nxt;
      s7_a3_r   <= s7_a3_nxt;
      s7_mv15_r <= s6_mv15_r;
      s7_mp2_r  <= s6_mp2_r;
      s7_q3m_r  <= hp3[52:32];
      s7_q4m_r  <= hp4[52:32];
      s7_q5m_r  <= hp5[52:32];
      s7_qneg_r <= {s6_x5_r[27], s6_x4_r[27], s6_x3_r[27]};
      s7_ts_r   <= s6_ts_r;
      s7_ap_r   <= s6_ap_r;
      s7_ah_r   <= s6_ah_r;

      s8_v2_r  <= s8_v2_nxt;
      s8_v3a_r <= s8_v3a_nxt;
      s8_q3_r  <= s8_q3_nxt;
      s8_q4_r  <= s8_q4_nxt;
      s8_q5_r  <= s8_q5_nxt;
      s8_ts_r  <= s7_ts_r;
      s8_ap_r  <= s7_ap_r;
      s8_ah_r  <= s7_ah_r;

      s9_prp_r <= s9_prp_nxt;
      s9_v3m_r <= s9_v3m_nxt;
      s9_v1h_r <= s9_v1h_nxt;
      s9_hs_r  <= s9_hs_nxt;
      s9_ts_r  <= s8_ts_r;

      s10_pr0_r  <= s10_pr0_nxt;
      s10_v3_r   <= s10_v3_nxt;
      s10_v2hp_r <= s10_v2hp_nxt;
      s10_v1h_r  <= s9_v1h_r;
      s10_ts_r   <= s9_ts_r;

      dv_rem_r[0]  <= '0;
      dv_num_r[0]  <= dv_num_nxt;
      dv_den_r[0]  <= dv_den_nxt;
      dv_side_r[0] <= dv_side_nxt;

      o1_prd_r  <= o1_prd_nxt;
      o1_hmp_r  <= o1_hmp_nxt;
      o1_zero_r <= dv_side_r[DVS].zero;
      o1_tsc_r  <= dv_side_r[DVS].tsc;

      o2_rl2_r  <= o2_rl2_nxt;
      o2_rhl_r  <= o2_rhl_nxt;
      o2_rh2_r  <= o2_rh2_nxt;
      o2_v2p_r  <= o2_v2p_nxt;
      o2_hm_r   <= o2_hm_nxt;
      o2_prd_r  <= o1_prd_r;
      o2_zero_r <= o1_zero_r;
      o2_tsc_r  <= o1_tsc_r;

      o3_rr_r   <= o3_rr_nxt;
      o3_v2s_r  <= 51'(o2_v2p_r >>> 13);
      o3_hm_r   <= o2_hm_r;
      o3_prd_r  <= o2_prd_r;
      o3_zero_r <= o2_zero_r;
      o3_tsc_r  <= o2_tsc_r;

      o4_pl_r   <= o4_pl_nxt;
      o4_ph_r   <= phf[31:0];
      o4_v2s_r  <= o3_v2s_r;
      o4_hm_r   <= o3_hm_r;
      o4_prd_r  <= o3_prd_r;
      o4_zero_r <= o3_zero_r;
      o4_tsc_r  <= o3_tsc_r;

      o5_v1_r   <= 39'(prod9 >>> 25);
      o5_v2s_r  <= o4_v2s_r;
      o5_hm_r   <= o4_hm_r;
      o5_prd_r  <= o4_prd_r;
      o5_zero_r <= o4_zero_r;
      o5_tsc_r  <= o4_tsc_r;

      o6_sm_r   <= o6_sm_nxt;
      o6_hm_r   <= o5_hm_r;
      o6_prd_r  <= o5_prd_r;
      o6_zero_r <= o5_zero_r;
      o6_tsc_r  <= o5_tsc_r;

      o7_pr_r    <= o7_pr_nxt;
      o7_hm_r    <= o6_hm_r;
      o7_tsc_r   <= o6_tsc_r;
      o7_guard_r <= o6_zero_r;
    end
  end

  // restoring divider, DBITS quotient bits per stage
  for (genvar g = 0; g < DVS; g++) begin : g_div
    logic [REM_W-1:0] rem_nxt;
    logic [DIV_W-1:0] num_nxt;

    always_comb begin
      rem_nxt = dv_rem_r[g];
      num_nxt = dv_num_r[g];
      for (int k = 0; k < DBITS; k++) begin
        rem_nxt = {rem_nxt[REM_W-2:0], num_nxt[DIV_W-1]};
        num_nxt = {num_nxt[DIV_W-2:0], 1'b0};
        if (rem_nxt >= {1'b0, dv_den_r[g]}) begin
          rem_nxt    = rem_nxt - {1'b0, dv_den_r[g]};
          num_nxt[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[g+1]  <= rem_nxt;
        dv_num_r[g+1]  <= num_nxt;
        dv_den_r[g+1]  <= dv_den_r[g];
        dv_side_r[g+1] <= dv_side_r[g];
      end
    end
  end

  assign out_temperature_centi = o7_tsc_r;
  assign out_pressure_pascal   = o7_pr_r;
  assign out_humidity_scaled   = o7_hm_r;
  assign out_divide_guard      = o7_guard_r;

endmodule
`default_nettype wire

FILE: sv/esc_checker.sv
// Port-level checks for environmental_sensor_compensation, bound to the top level.
// Depends on esc_pkg.
`default_nettype none
module esc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [17:0] out_pressure_pascal,
  input wire logic [16:0] out_humidity_scaled,
  input wire logic        out_divide_guard
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_guard_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_guard |-> out_pressure_pascal == '0)
    else $error("divide guard with nonzero pressure");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_humidity_scaled <= esc_pkg::HUM_MAX)
    else $error("humidity above full scale");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("item taken while pipeline frozen");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("valid after reset");

endmodule

bind environmental_sensor_compensation esc_checker u_esc_checker (.*);
`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for environmental_sensor_compensation: results for raw sample
// items are compared with a 64-bit integer predictor. Depends on esc_pkg and the block RTL.
`default_nettype none
typedef struct {
  logic signed [15:0] temp;
  logic [17:0]        press;
  logic [16:0]        hum;
  logic               guard;
} comp_result_t;

class comp_scoreboard;
  logic [47:0]  coeffs [5];
  comp_result_t expected_q [$];
  int           errors;
  int           checked;
  int           guards;

  function new();
    foreach (coeffs[i]) coeffs[i] = '0;
    errors = 0;
    checked = 0;
    guards = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [47:0] val);
    case (idx)
      esc_pkg::CFG_TEMP, esc_pkg::CFG_PRESS_A, esc_pkg::CFG_PRESS_B,
      esc_pkg::CFG_PRESS_C: coeffs[idx] = {8'd0, val[39:0]};
      esc_pkg::CFG_HUM: coeffs[idx] = val;
      default: ;
    endcase
  endfunction

  static function longint quot(longint a, longint b);
    if (b == -1) return -a;
    return a / b;
  endfunction

  static function longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function comp_result_t compensate(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
    comp_result_t res;
    logic [47:0] tc, pa, pb, pc, hc;
    longint at, ap, ah, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint h1, h2, h3, h4, h5, v1, v2, v3, d, q, sq, tf, ts, pr, r, hm;
    tc = coeffs[esc_pkg::CFG_TEMP];
    pa = coeffs[esc_pkg::CFG_PRESS_A];
    pb = coeffs[esc_pkg::CFG_PRESS_B];
    pc = coeffs[esc_pkg::CFG_PRESS_C];
    hc = coeffs[esc_pkg::CFG_HUM];
    at = longint'(rt);
    ap = longint'(rp);
    ah = longint'(rh);
    t1 = longint'(tc[15:0]);
    t2 = longint'($signed(tc[31:16]));
    t3 = longint'($signed(tc[39:32]));
    p1 = longint'(pa[15:0]);
    p2 = longint'($signed(pa[31:16]));
    p3 = longint'($signed(pa[39:32]));
    p4 = longint'($signed(pb[15:0]));
    p5 = longint'($signed(pb[31:16]));
    p6 = longint'($signed(pb[39:32]));
    p7 = longint'($signed(pc[7:0]));
    p8 = longint'($signed(pc[23:8]));
    p9 = longint'($signed(pc[39:24]));
    h1 = longint'(hc[11:0]);
    h2 = longint'(hc[23:12]);
    h3 = longint'($signed(hc[31:24]));
    h4 = longint'($signed(hc[39:32]));
    h5 = longint'($signed(hc[47:40]));

    v1 = (((at >>> 3) - t1 * 2) * t2) >>> 11;
    d  = (at >>> 4) - t1;
    v2 = (((d * d) >>> 12) * t3) >>> 14;
    tf = v1 + v2;
    ts = (tf * 5 + 128) >>> 8;

    v1 = (tf >>> 1) - 64'sd64000;
    q  = v1 >>> 2;
    sq = q * q;
    v2 = (sq >>> 11) * p6;
    v2 = v2 + v1 * p5 * 2;
    v2 = (v2 >>> 2) + p4 * 64'sd65536;
    v3 = (((p3 * (sq >>> 13)) >>> 3) + ((p2 * v1) >>> 1)) >>> 18;
    v3 = ((64'sd32768 + v3) * p1) >>> 15;
    res.guard = (v3 == 0);
    if (v3 == 0) begin
      pr = 0;
    end else begin
      pr = ((64'sd1048576 - ap) - (v2 >>> 12)) * 64'sd3125;
      if (pr >= 64'sd2147483648) pr = quot(pr, v3) * 2;
      else pr = quot(pr * 2, v3);
      r  = pr >>> 3;
      v1 = ((p9 * (r * r)) >>> 13) >>> 12;
      v2 = ((pr >>> 2) * p8) >>> 13;
      pr = pr + ((v1 + v2 + p7) >>> 4);
      pr = clip(pr, 0, 262143);
    end

    v1 = (ah - h1 * 16) - (quot(ts * h3, 100) >>> 1);
    v2 = (h2 * (quot(ts * h4, 100) + (quot(ts * h5, 100) >>> 6) + 64'sd16384)) >>> 10;
    hm = clip(v1 * v2, 0, 102400);

    res.temp  = 16'(clip(ts, -32768, 32767));
    res.press = 18'(pr);
    res.hum   = 17'(hm);
    return res;
  endfunction

  function void note_item(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
    expected_q.push_back(compensate(rt, rp, rh));
  endfunction

  task report(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  task check_result(comp_result_t got);
    comp_result_t want;
    if (expected_q.size() == 0) begin
      report("unexpected result, temperature", got.temp, 0);
      return;
    end
    want = expected_q.pop_front();
    checked++;
    if (want.guard) guards++;
    if (got.temp !== want.temp) report("temperature", got.temp, want.temp);
    if (got.press !== want.press) report("pressure", got.press, want.press);
    if (got.hum !== want.hum) report("humidity", got.hum, want.hum);
    if (got.guard !== want.guard) report("divide guard", got.guard, want.guard);
  endtask

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_top;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = esc_pkg::LATENCY + 10;
  localparam logic [esc_pkg::CFG_IDX_W-1:0] SPARE_IDX_LO = 3'd5;
  localparam logic [esc_pkg::CFG_IDX_W-1:0] SPARE_IDX_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [19:0] in_raw_temperature = '0;
  logic [19:0] in_raw_pressure = '0;
  logic [15:0] in_raw_humidity = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_temperature_centi;
  logic [17:0] out_pressure_pascal;
  logic [16:0] out_humidity_scaled;
  logic out_divide_guard;
  logic cfg_we = 1'b0;
  logic [esc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [esc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  comp_scoreboard sb = new();
  bit  stall_rx = 1'b0;
  int  long_hold_req = 0;
  int  quiet_cycles = 0;
  int  items_sent = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  environmental_sensor_compensation i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_raw_temperature    (in_raw_temperature),
    .in_raw_pressure       (in_raw_pressure),
    .in_raw_humidity       (in_raw_humidity),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_temperature_centi (out_temperature_centi),
    .out_pressure_pascal   (out_pressure_pascal),
    .out_humidity_scaled   (out_humidity_scaled),
    .out_divide_guard      (out_divide_guard),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  // monitors and watchdog
  always @(posedge clk) begin
    comp_result_t got;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (in_valid && in_ready) sb.note_item(in_raw_temperature, in_raw_pressure, in_raw_humidity);
      if (out_valid && out_ready) begin
        got.temp  = out_temperature_centi;
        got.press = out_pressure_pascal;
        got.hum   = out_humidity_scaled;
        got.guard = out_divide_guard;
        sb.check_result(got);
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d items outstanding", sb.pending());
        $display("FAIL");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req > 0) begin
        hold = long_hold_req;
        long_hold_req = 0;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (stall_rx && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        hold = $urandom_range(1, 17) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // all driving tasks start and end on a falling edge
  task send_sample(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
    in_valid           <= 1'b1;
    in_raw_temperature <= rt;
    in_raw_pressure    <= rp;
    in_raw_humidity    <= rh;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  task pause_input(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task write_coeff(logic [esc_pkg::CFG_IDX_W-1:0] idx, logic [esc_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // plausible calibration set with a little spread
  task load_typical();
    logic [15:0] t1, p1;
    logic signed [15:0] t2, p2, p4, p5, p8, p9;
    logic signed [7:0] t3, p3, p6, p7, h3, h4, h5;
    logic [11:0] h1, h2;
    t1 = 16'(26000 + $urandom_range(0, 2000));
    t2 = 16'(26000 + $urandom_range(0, 1000));
    t3 = 8'($urandom_range(0, 6));
    p1 = 16'(35000 + $urandom_range(0, 3000));
    p2 = -16'sd10300 + 16'($urandom_range(0, 600));
    p3 = 8'sd88;
    p4 = 16'(6800 + $urandom_range(0, 600));
    p5 = -16'sd100 + 16'($urandom_range(0, 60));
    p6 = 8'sd30;
    p7 = 8'sd40;
    p8 = -16'sd200 + 16'($urandom_range(0, 60));
    p9 = -16'sd3000 + 16'($urandom_range(0, 300));
    h1 = 12'(650 + $urandom_range(0, 150));
    h2 = 12'(950 + $urandom_range(0, 150));
    h3 = 8'($urandom_range(0, 255));
    h4 = 8'($urandom_range(0, 255));
    h5 = 8'($urandom_range(0, 255));
    write_coeff(esc_pkg::CFG_TEMP, {8'd0, t3, t2, t1});
    write_coeff(esc_pkg::CFG_PRESS_A, {8'd0, p3, p2, p1});
    write_coeff(esc_pkg::CFG_PRESS_B, {8'd0, p6, p5, p4});
    write_coeff(esc_pkg::CFG_PRESS_C, {8'd0, p9, p8, p7});
    write_coeff(esc_pkg::CFG_HUM, {h5, h4, h3, h2, h1});
  endtask

  task load_uniform(logic [esc_pkg::CFG_DATA_W-1:0] val);
    write_coeff(esc_pkg::CFG_TEMP, val);
    write_coeff(esc_pkg::CFG_PRESS_A, val);
    write_coeff(esc_pkg::CFG_PRESS_B, val);
    write_coeff(esc_pkg::CFG_PRESS_C, val);
    write_coeff(esc_pkg::CFG_HUM, val);
  endtask

  function automatic logic [esc_pkg::CFG_DATA_W-1:0] rand48();
    return {16'($urandom()), $urandom()};
  endfunction

  task random_sample(bit plausible);
    if (plausible)
      send_sample(20'(400000 + $urandom_range(0, 200000)),
                  20'(250000 + $urandom_range(0, 250000)),
                  16'(15000 + $urandom_range(0, 30000)));
    else
      send_sample(20'($urandom()), 20'($urandom()), 16'($urandom()));
  endtask

  task run_phase(int n, bit idle);
    repeat (n) begin
      if (idle && $urandom_range(0, 9) == 0) pause_input($urandom_range(1, 17));
      random_sample($urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    int phase;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset coefficients: divisor is zero, guard path
    send_sample('0, '0, '0);
    send_sample('1, '1, '1);
    send_sample(20'h80000, 20'h7FFFF, 16'h8000);
    send_sample(20'h7FFFF, 20'h80000, 16'h7FFF);
    wait_drained();

    // writes to unused indexes must leave the coefficients alone
    load_typical();
    write_coeff(SPARE_IDX_LO, '1);
    write_coeff(SPARE_IDX_HI, rand48());
    send_sample(20'd500000, 20'd400000, 16'd30000);
    send_sample('0, '0, '0);
    send_sample('1, '1, '1);
    send_sample(20'd520000, 20'd0, 16'd0);
    send_sample(20'd480000, '1, '1);
    send_sample(20'd300000, 20'd100000, 16'd60000);
    wait_drained();

    // extreme coefficient sets: all ones, then all zero but p1
    load_uniform('1);
    send_sample('0, '0, '0);
    send_sample('1, '1, '1);
    send_sample(20'h55555, 20'hAAAAA, 16'h5A5A);
    wait_drained();
    load_uniform('0);
    write_coeff(esc_pkg::CFG_PRESS_A, 48'h0000_0000_FFFF);
    send_sample('1, '0, '1);
    send_sample('0, '1, '0);
    wait_drained();

    stall_rx = 1'b1;
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 3)
        0: load_typical();
        1: load_uniform(rand48());
        default: begin
          write_coeff(esc_pkg::CFG_TEMP, rand48());
          write_coeff(esc_pkg::CFG_PRESS_A, rand48());
          write_coeff(esc_pkg::CFG_PRESS_B, rand48());
          write_coeff(esc_pkg::CFG_PRESS_C, rand48());
          write_coeff(esc_pkg::CFG_HUM, rand48());
        end
      endcase
      if (phase == 2) begin
        // long output stall with the input kept busy
        long_hold_req = 300;
        run_phase(80, 1'b0);
      end
      run_phase(150, 1'b1);
      if (phase == 4) begin
        wait_drained();
        run_phase(20, 1'b1);
      end
      wait_drained();
    end

    // closing stretch without any idling
    stall_rx = 1'b0;
    load_typical();
    run_phase(280, 1'b0);
    wait_drained();

    $display("%0d samples sent, %0d results checked, %0d with the divide guard set",
             items_sent, sb.checked, sb.guards);
    $display("coefficient sets covered: reset, typical, all ones, zero, random");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
